/* src/ipv4hc_pkg.sv */
package ipv4hc_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] status;
    logic [7:0] payload_byte;
    logic       end_of_packet;
  } out_word_t;

  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_VERSION   = 3'd1;
  localparam logic [2:0] STATUS_HDR_LEN   = 3'd2;
  localparam logic [2:0] STATUS_TTL       = 3'd3;
  localparam logic [2:0] STATUS_CHECKSUM  = 3'd4;
  localparam logic [2:0] STATUS_DEST      = 3'd5;
  localparam logic [2:0] STATUS_TRUNCATED = 3'd6;

  localparam logic [4:0] POS_VERSION     = 5'd0;
  localparam logic [4:0] POS_TTL         = 5'd8;
  localparam logic [4:0] POS_CHECKSUM_LO = 5'd11;
  localparam logic [4:0] POS_DEST_FIRST  = 5'd16;
  localparam logic [4:0] POS_LAST_HEADER = 5'd19;
  localparam logic [4:0] HEADER_BYTES    = 5'd20;

  localparam logic [3:0]  IP_VERSION    = 4'd4;
  localparam logic [3:0]  IP_HDR_WORDS  = 4'd5;
  localparam logic [31:0] ADDR_BROADCAST = 32'hffff_ffff;

endpackage

/* src/ipv4hc_check.sv */
module ipv4hc_check (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  ipv4hc_pkg::in_word_t item,
  input  logic [31:0]          host_address,
  output logic                 res_valid,
  output ipv4hc_pkg::out_word_t res_data
);

  logic [4:0]  pos_r,    pos_nxt;
  logic [15:0] sum_r,    sum_nxt;
  logic [7:0]  hold_r,   hold_nxt;
  logic [15:0] csum_r,   csum_nxt;
  logic [31:0] dest_r,   dest_nxt;
  logic [2:0]  err_r,    err_nxt;
  logic        accept_r, accept_nxt;

  logic [15:0] word;
  logic [16:0] sum_wide;
  logic [15:0] sum_fold;

  assign word     = {hold_r, item.data_byte};
  assign sum_wide = {1'b0, sum_r} + {1'b0, word};
  assign sum_fold = sum_wide[15:0] + {15'd0, sum_wide[16]};

  always_comb begin
    pos_nxt    = pos_r;
    sum_nxt    = sum_r;
    hold_nxt   = hold_r;
    csum_nxt   = csum_r;
    dest_nxt   = dest_r;
    err_nxt    = err_r;
    accept_nxt = accept_r;
    res_valid  = 1'b0;
    res_data   = '0;

    if (pos_r >= ipv4hc_pkg::HEADER_BYTES) begin
      if (accept_r) begin
        res_valid              = 1'b1;
        res_data.kind          = ipv4hc_pkg::KIND_PAYLOAD;
        res_data.status        = ipv4hc_pkg::STATUS_OK;
        res_data.payload_byte  = item.data_byte;
        res_data.end_of_packet = item.last_byte;
      end
    end else begin
      if (pos_r == ipv4hc_pkg::POS_VERSION) begin
        if (err_nxt == ipv4hc_pkg::STATUS_OK &&
            item.data_byte[7:4] != ipv4hc_pkg::IP_VERSION) begin
          err_nxt = ipv4hc_pkg::STATUS_VERSION;
        end
        if (err_nxt == ipv4hc_pkg::STATUS_OK &&
            item.data_byte[3:0] != ipv4hc_pkg::IP_HDR_WORDS) begin
          err_nxt = ipv4hc_pkg::STATUS_HDR_LEN;
        end
      end
      if (pos_r == ipv4hc_pkg::POS_TTL && item.data_byte == 8'd0 &&
          err_nxt == ipv4hc_pkg::STATUS_OK) begin
        err_nxt = ipv4hc_pkg::STATUS_TTL;
      end

      if (!pos_r[0]) begin
        hold_nxt = item.data_byte;
      end else if (pos_r == ipv4hc_pkg::POS_CHECKSUM_LO) begin
        csum_nxt = word;
      end else begin
        sum_nxt = sum_fold;
      end

      if (pos_r >= ipv4hc_pkg::POS_DEST_FIRST) begin
        dest_nxt = {dest_r[23:0], item.data_byte};
      end

      if (pos_r == ipv4hc_pkg::POS_LAST_HEADER) begin
        if (err_nxt == ipv4hc_pkg::STATUS_OK && csum_nxt != ~sum_nxt) begin
          err_nxt = ipv4hc_pkg::STATUS_CHECKSUM;
        end
        if (err_nxt == ipv4hc_pkg::STATUS_OK && dest_nxt != host_address &&
            dest_nxt != ipv4hc_pkg::ADDR_BROADCAST) begin
          err_nxt = ipv4hc_pkg::STATUS_DEST;
        end
        res_valid              = 1'b1;
        res_data.kind          = ipv4hc_pkg::KIND_VERDICT;
        res_data.status        = err_nxt;
        res_data.end_of_packet = item.last_byte;
        accept_nxt             = (err_nxt == ipv4hc_pkg::STATUS_OK);
        pos_nxt                = ipv4hc_pkg::HEADER_BYTES;
      end else begin
        if (item.last_byte) begin
          res_valid              = 1'b1;
          res_data.kind          = ipv4hc_pkg::KIND_VERDICT;
          res_data.status        = ipv4hc_pkg::STATUS_TRUNCATED;
          res_data.end_of_packet = 1'b1;
        end
        pos_nxt = pos_r + 5'd1;
      end
    end

    if (item.last_byte) begin
      pos_nxt    = '0;
      sum_nxt    = '0;
      hold_nxt   = '0;
      csum_nxt   = '0;
      dest_nxt   = '0;
      err_nxt    = ipv4hc_pkg::STATUS_OK;
      accept_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      sum_r    <= '0;
      hold_r   <= '0;
      csum_r   <= '0;
      dest_r   <= '0;
      err_r    <= ipv4hc_pkg::STATUS_OK;
      accept_r <= 1'b0;
    end else if (step) begin
      pos_r    <= pos_nxt;
      sum_r    <= sum_nxt;
      hold_r   <= hold_nxt;
      csum_r   <= csum_nxt;
      dest_r   <= dest_nxt;
      err_r    <= err_nxt;
      accept_r <= accept_nxt;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.last_byte |=> pos_r == '0 && err_r == ipv4hc_pkg::STATUS_OK && !accept_r)
    else $error("per-packet state not cleared after the last byte");

  a_accept_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
    accept_r |-> pos_r == ipv4hc_pkg::HEADER_BYTES)
    else $error("payload forwarding enabled outside the payload");

  a_verdict_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
    step && !item.last_byte && pos_r == ipv4hc_pkg::POS_LAST_HEADER
    |=> pos_r == ipv4hc_pkg::HEADER_BYTES)
    else $error("position did not advance into the payload after the verdict");

  a_payload_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_data.kind == ipv4hc_pkg::KIND_PAYLOAD |-> accept_r)
    else $error("payload word forwarded for a rejected packet");

endmodule

/* src/ipv4hc_out_reg.sv */
module ipv4hc_out_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  logic                  res_valid,
  input  ipv4hc_pkg::out_word_t res_data,
  output logic                  space,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ipv4hc_pkg::out_word_t out_data
);

  logic                  valid_r, valid_nxt;
  ipv4hc_pkg::out_word_t data_r,  data_nxt;

  assign space     = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt = res_valid;
      data_nxt  = res_data;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

/* src/ipv4_header_receive_check.sv */
// An input word is held in the input register; its result word leaves from the result register.
// Throughput: one word per cycle unless out_ready stalls; the ones'-complement add and fold
// and the destination compare are combinational between the input and result registers.
// Reset: synchronous, active low; clears the host address, the header position and
// all per-packet check state, and empties both pipeline registers.
module ipv4_header_receive_check (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ipv4hc_pkg::in_word_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ipv4hc_pkg::out_word_t out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [31:0]           cfg_data
);

  logic                  s1_valid_r, s1_valid_nxt;
  ipv4hc_pkg::in_word_t  s1_data_r;
  logic [31:0]           host_address_r;
  logic                  space;
  logic                  step;
  logic                  res_valid;
  ipv4hc_pkg::out_word_t res_data;

  assign cfg_ready = 1'b1;
  assign step      = s1_valid_r && space;
  assign in_ready  = !s1_valid_r || step;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (step) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      host_address_r <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        host_address_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  ipv4hc_check u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .item         (s1_data_r),
    .host_address (host_address_r),
    .res_valid    (res_valid),
    .res_data     (res_data)
  );

  ipv4hc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .res_valid (res_valid),
    .res_data  (res_data),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
